@@ hdl/utf8v_pkg.sv @@
// Types and byte constants shared by the UTF-8 text validator.
package utf8v_pkg;

    localparam int unsigned BYTE_TOTAL_W = 13;
    localparam int unsigned MAX_LEN_W    = 13;
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 13'd4096;

    localparam logic [7:0] CTRL_END    = 8'h20;
    localparam logic [7:0] DEL_CHAR    = 8'h7F;
    localparam logic [7:0] ASCII_END   = 8'h80;
    localparam logic [7:0] LEAD2_LO    = 8'hC2;
    localparam logic [7:0] LEAD2_HI    = 8'hDF;
    localparam logic [7:0] LEAD3_LO    = 8'hE0;
    localparam logic [7:0] LEAD3_HI    = 8'hEF;
    localparam logic [7:0] LEAD3_SURR  = 8'hED;
    localparam logic [7:0] LEAD4_LO    = 8'hF0;
    localparam logic [7:0] LEAD4_HI    = 8'hF4;
    localparam logic [7:0] BOUND_A0    = 8'hA0;
    localparam logic [7:0] BOUND_90    = 8'h90;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;

    typedef enum logic [2:0] {
        RULE_NONE,
        RULE_MIN_A0,
        RULE_BELOW_A0,
        RULE_MIN_90,
        RULE_BELOW_90
    } second_rule_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       has_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic                    text_valid;
        logic [BYTE_TOTAL_W-1:0] byte_total;
    } out_item_t;

    typedef struct packed {
        logic [1:0]   pending;
        second_rule_t rule;
        logic         error;
    } seq_state_t;

endpackage

@@ hdl/utf8_text_validator_top.sv @@
// Top level of the UTF-8 text validator: input register, text state, verdict register.
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    in_item_t  (byte, has_byte, end_of_text)
//  m_       out        m_valid / m_ready    out_item_t (text_valid, byte_total)
//  cfg_     in         cfg_we               cfg_wdata  (max_length)
//
// One item per clock sustained while no end item waits on a stalled result.
// A verdict is loaded into the result register at the edge that takes its end item
// out of the input register, and m_valid is driven from that result register.
// A stalled result holds an end item in the input register and the input behind it; a non-end item is still consumed.
// Synchronous active-low reset: text state cleared, max_length back to 4096.
module utf8_text_validator_top #(
    parameter int unsigned LENGTH_LIMIT = 4096
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  utf8v_pkg::in_item_t                   s_item,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output utf8v_pkg::out_item_t                  m_item,
    input  logic                                  cfg_we,
    input  logic [utf8v_pkg::MAX_LEN_W-1:0]       cfg_wdata
);

    localparam int unsigned CNT_W = $clog2(LENGTH_LIMIT + 2);
    localparam int unsigned MW    = (CNT_W > utf8v_pkg::MAX_LEN_W) ? CNT_W : utf8v_pkg::MAX_LEN_W;
    localparam logic [MW:0] LIMIT_EXT = (MW + 1)'(LENGTH_LIMIT);

    logic [utf8v_pkg::MAX_LEN_W-1:0] max_length_reg;

    utf8v_pkg::in_item_t   in_item_reg;
    logic                  in_valid_reg;
    logic                  in_consume;

    utf8v_pkg::seq_state_t seq_reg, seq_next, seq_upd;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    utf8v_pkg::out_item_t  m_item_reg, m_item_next;
    logic                  m_valid_reg;
    logic                  out_free;

    logic [MW:0] max_ext, eff_max, cnt_upd_ext, cnt_ext;
    logic        verdict;

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn)
            max_length_reg <= utf8v_pkg::MAX_LEN_RESET;
        else if (cfg_we)
            max_length_reg <= cfg_wdata;
    end

    assign max_ext = (MW + 1)'(max_length_reg);
    assign eff_max = (max_ext > LIMIT_EXT) ? LIMIT_EXT : max_ext;

    assign out_free   = !m_valid_reg || m_ready;
    assign in_consume = in_valid_reg && (!in_item_reg.end_of_text || out_free);
    assign s_ready    = !in_valid_reg || in_consume;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            in_valid_reg <= 1'b0;
        else if (s_ready)
            in_valid_reg <= s_valid;
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid)
            in_item_reg <= s_item;
    end

    utf8v_check u_check (
        .st        (seq_reg),
        .text_byte (in_item_reg.text_byte),
        .has_byte  (in_item_reg.has_byte),
        .st_next   (seq_upd)
    );

    // saturating count, stops at effective max plus one
    assign cnt_ext = (MW + 1)'(cnt_reg);
    always_comb begin
        cnt_next = cnt_reg;
        if (in_item_reg.has_byte && cnt_ext <= eff_max)
            cnt_next = CNT_W'(cnt_reg + 1'b1);
    end
    assign cnt_upd_ext = (MW + 1)'(cnt_next);

    assign verdict = !seq_upd.error && (cnt_next != '0) && (cnt_upd_ext <= eff_max)
                     && (seq_upd.pending == 2'd0);

    always_comb begin
        m_item_next.text_valid = verdict;
        m_item_next.byte_total = cnt_upd_ext[utf8v_pkg::BYTE_TOTAL_W-1:0];
        seq_next               = seq_upd;
        if (in_item_reg.end_of_text)
            seq_next = '{pending: 2'd0, rule: utf8v_pkg::RULE_NONE, error: 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg <= '{pending: 2'd0, rule: utf8v_pkg::RULE_NONE, error: 1'b0};
            cnt_reg <= '0;
        end else if (in_consume) begin
            seq_reg <= seq_next;
            cnt_reg <= in_item_reg.end_of_text ? '0 : cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_valid_reg <= 1'b0;
        else if (in_consume && in_item_reg.end_of_text)
            m_valid_reg <= 1'b1;
        else if (m_ready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (in_consume && in_item_reg.end_of_text)
            m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // text state is back to its cleared value after every verdict
    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        in_consume && in_item_reg.end_of_text |=>
            cnt_reg == '0 && seq_reg.pending == 2'd0 && !seq_reg.error)
        else $error("text state not cleared after end item");

    // a passing text always has at least one byte
    a_valid_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.text_valid |-> m_item_reg.byte_total != '0)
        else $error("valid verdict with zero byte count");

    // error stays set until the end of the text
    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg.error && in_consume && !in_item_reg.end_of_text |=> seq_reg.error)
        else $error("error flag dropped inside a text");

    // only a waiting end item can hold the input side
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && in_item_reg.end_of_text && m_valid_reg && !m_ready)
        else $error("input stalled without a blocked end item");

endmodule

@@ hdl/utf8v_check.sv @@
// Per-byte UTF-8 sequence checker: next sequence state from current state and byte.
module utf8v_check (
    input  utf8v_pkg::seq_state_t st,
    input  logic [7:0]            text_byte,
    input  logic                  has_byte,
    output utf8v_pkg::seq_state_t st_next
);

    logic [7:0] b;
    assign b = text_byte;

    always_comb begin
        st_next = st;
        if (has_byte && !st.error) begin
            if (st.pending == 2'd0) begin
                if (b < utf8v_pkg::CTRL_END || b == utf8v_pkg::DEL_CHAR) begin
                    st_next.error = 1'b1;
                end else if (b < utf8v_pkg::ASCII_END) begin
                    st_next = st;
                end else if (b >= utf8v_pkg::LEAD2_LO && b <= utf8v_pkg::LEAD2_HI) begin
                    st_next.pending = 2'd1;
                    st_next.rule    = utf8v_pkg::RULE_NONE;
                end else if (b >= utf8v_pkg::LEAD3_LO && b <= utf8v_pkg::LEAD3_HI) begin
                    st_next.pending = 2'd2;
                    if (b == utf8v_pkg::LEAD3_LO)
                        st_next.rule = utf8v_pkg::RULE_MIN_A0;
                    else if (b == utf8v_pkg::LEAD3_SURR)
                        st_next.rule = utf8v_pkg::RULE_BELOW_A0;
                    else
                        st_next.rule = utf8v_pkg::RULE_NONE;
                end else if (b >= utf8v_pkg::LEAD4_LO && b <= utf8v_pkg::LEAD4_HI) begin
                    st_next.pending = 2'd3;
                    if (b == utf8v_pkg::LEAD4_LO)
                        st_next.rule = utf8v_pkg::RULE_MIN_90;
                    else if (b == utf8v_pkg::LEAD4_HI)
                        st_next.rule = utf8v_pkg::RULE_BELOW_90;
                    else
                        st_next.rule = utf8v_pkg::RULE_NONE;
                end else begin
                    st_next.error = 1'b1;
                end
            end else begin
                // continuation byte, second-byte bound applies once after the lead
                case (st.rule)
                    utf8v_pkg::RULE_MIN_A0:   if (b <  utf8v_pkg::BOUND_A0) st_next.error = 1'b1;
                    utf8v_pkg::RULE_BELOW_A0: if (b >= utf8v_pkg::BOUND_A0) st_next.error = 1'b1;
                    utf8v_pkg::RULE_MIN_90:   if (b <  utf8v_pkg::BOUND_90) st_next.error = 1'b1;
                    utf8v_pkg::RULE_BELOW_90: if (b >= utf8v_pkg::BOUND_90) st_next.error = 1'b1;
                    default: ;
                endcase
                if ((b & utf8v_pkg::CONT_MASK) != utf8v_pkg::CONT_TAG)
                    st_next.error = 1'b1;
                st_next.pending = st.pending - 2'd1;
                st_next.rule    = utf8v_pkg::RULE_NONE;
            end
        end
    end

endmodule
